[rtl/parrs_pkg.sv]
// Shared types, codes and constants of the aging round-robin scheduler.
package parrs_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int ID_WIDTH_DEF = 16;

  localparam logic [14:0] SLICE_RESET   = 15'd10;
  localparam logic [14:0] IO_WAIT_RESET = 15'd20;
  localparam logic [3:0]  AGING_RESET   = 4'd5;

  localparam logic [1:0] PRIO_TOP = 2'd0;
  localparam logic [1:0] PRIO_ADD = 2'd1;
  localparam logic [1:0] PRIO_MAX = 2'd2;

  localparam logic [1:0] Q_READY = 2'd0;
  localparam logic [1:0] Q_WAIT  = 2'd1;
  localparam logic [1:0] Q_NONE  = 2'd2;

  typedef enum logic [1:0] {
    CFG_SLICE   = 2'd0,
    CFG_IO_WAIT = 2'd1,
    CFG_AGING   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2,
    OP_SETP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_PRIO  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PASS_EXPIRE,
    PASS_PREFIX,
    PASS_UPDATE,
    PASS_DISPATCH,
    PASS_FIND,
    PASS_REMOVE
  } pass_t;

  typedef struct packed {
    logic    start;
    pass_t   pass;
    logic    tick_begin;
    logic    add_write;
    logic    finish_runner;
    logic    setp_runner;
    logic    setp_wr;
    logic    out_load;
    status_t status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic scan_done;
    logic full;
    logic runner_hit;
    logic prio_bad;
    logic found;
    logic dispatch_ok;
    logic out_free;
  } sts_t;

endpackage

[rtl/parrs_if.sv]
// Item and configuration channel interfaces of the scheduler.
interface parrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] task_id;
  logic [1:0]  new_priority;
  logic        io_request;
  modport source (output valid, op, task_id, new_priority, io_request, input ready);
  modport sink (input valid, op, task_id, new_priority, io_request, output ready);
endinterface

interface parrs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        run_valid;
  logic [15:0] run_id;
  logic [1:0]  run_priority;
  logic [6:0]  ready_count;
  logic [6:0]  wait_count;
  modport source (output valid, status, run_valid, run_id, run_priority, ready_count,
                  wait_count, input ready);
  modport sink (input valid, status, run_valid, run_id, run_priority, ready_count,
                wait_count, output ready);
endinterface

interface parrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/parrs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module parrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/parrs_ctrl.sv]
// Sequencer that steps each item through its slot-table sweeps.
module parrs_ctrl import parrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXPIRE,
    S_PREFIX,
    S_UPDATE,
    S_UPD_POST,
    S_DISPATCH,
    S_FIND,
    S_FIND_POST,
    S_REMOVE,
    S_DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b0;
      cmd      <= '0;
    end else begin
      cmd.start         <= 1'b0;
      cmd.tick_begin    <= 1'b0;
      cmd.add_write     <= 1'b0;
      cmd.finish_runner <= 1'b0;
      cmd.setp_runner   <= 1'b0;
      cmd.setp_wr       <= 1'b0;
      cmd.out_load      <= 1'b0;
      unique case (state)
        S_IDLE: begin
          in_ready <= 1'b1;
          if (in_fire) begin
            in_ready <= 1'b0;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          cmd.status <= ST_OK;
          unique case (sts.op)
            OP_TICK: begin
              cmd.tick_begin <= 1'b1;
              cmd.start      <= 1'b1;
              cmd.pass       <= PASS_EXPIRE;
              state          <= S_EXPIRE;
            end
            OP_ADD: begin
              if (sts.full) begin
                cmd.status <= ST_FULL;
              end else begin
                cmd.add_write <= 1'b1;
              end
              state <= S_DONE;
            end
            OP_FINISH: begin
              if (sts.runner_hit) begin
                cmd.finish_runner <= 1'b1;
                state             <= S_DONE;
              end else begin
                cmd.start <= 1'b1;
                cmd.pass  <= PASS_FIND;
                state     <= S_FIND;
              end
            end
            OP_SETP: begin
              if (sts.prio_bad) begin
                cmd.status <= ST_BAD_PRIO;
                state      <= S_DONE;
              end else if (sts.runner_hit) begin
                cmd.setp_runner <= 1'b1;
                state           <= S_DONE;
              end else begin
                cmd.start <= 1'b1;
                cmd.pass  <= PASS_FIND;
                state     <= S_FIND;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_EXPIRE: begin
          if (sts.scan_done) begin
            cmd.start <= 1'b1;
            cmd.pass  <= PASS_PREFIX;
            state     <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          if (sts.scan_done) begin
            cmd.start <= 1'b1;
            cmd.pass  <= PASS_UPDATE;
            state     <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (sts.scan_done) begin
            state <= S_UPD_POST;
          end
        end
        S_UPD_POST: begin
          if (sts.dispatch_ok) begin
            cmd.start <= 1'b1;
            cmd.pass  <= PASS_DISPATCH;
            state     <= S_DISPATCH;
          end else begin
            state <= S_DONE;
          end
        end
        S_DISPATCH: begin
          if (sts.scan_done) begin
            state <= S_DONE;
          end
        end
        S_FIND: begin
          if (sts.scan_done) begin
            state <= S_FIND_POST;
          end
        end
        S_FIND_POST: begin
          if (!sts.found) begin
            cmd.status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else if (sts.op == OP_FINISH) begin
            cmd.start <= 1'b1;
            cmd.pass  <= PASS_REMOVE;
            state     <= S_REMOVE;
          end else begin
            cmd.setp_wr <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_REMOVE: begin
          if (sts.scan_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (sts.out_free) begin
            cmd.out_load <= 1'b1;
            in_ready     <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/parrs_dp.sv]
// Slot table, queue bookkeeping, sweep pipeline and result register.
module parrs_dp import parrs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_task_id,
  input  logic [1:0]  in_new_priority,
  input  logic        in_io_request,
  input  logic        cfg_fire,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_run_valid,
  output logic [15:0] out_run_id,
  output logic [1:0]  out_run_priority,
  output logic [6:0]  out_ready_count,
  output logic [6:0]  out_wait_count
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [1:0]          q;
    logic [1:0]          prio;
    logic [3:0]          age;
    logic [SW-1:0]       rank;
    logic [15:0]         stamp;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic [14:0]         slice_ticks;
  logic [14:0]         io_wait_ticks;
  logic [3:0]          aging_threshold;
  logic [SLOTS-1:0]    used;
  logic                runner_valid;
  logic [SW-1:0]       runner_slot;
  logic [ID_WIDTH-1:0] runner_id;
  logic [1:0]          runner_prio;
  logic [15:0]         runner_stamp;
  logic [15:0]         tick_count;
  logic [CW-1:0]       ready_total;
  logic [CW-1:0]       wait_total;

  op_t                 op_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [1:0]          np_q;
  logic                io_q;

  logic [SLOTS-1:0]    expired;
  logic [CW-1:0]       exp_count;
  logic                preempt;
  logic                runner_after;

  logic                best_valid;
  logic [SW-1:0]       best_slot;
  logic [1:0]          best_prio;
  logic [SW-1:0]       best_rank;
  logic [ID_WIDTH-1:0] best_id;

  logic                found;
  logic [SW-1:0]       found_slot;
  logic [1:0]          found_q;
  logic [SW-1:0]       found_rank;
  entry_t              found_entry;

  logic                issuing;
  logic [SW-1:0]       idx;
  logic                s1_valid;
  logic [SW-1:0]       s1_idx;
  logic                s2_valid;
  logic [SW-1:0]       s2_idx;
  entry_t              e2;

  logic [EW-1:0]       ent_rdata;
  entry_t              e1;
  logic                ent_we;
  logic [SW-1:0]       ent_waddr;
  entry_t              ent_wdata;
  logic [CW-1:0]       below;
  logic                pre_we;

  entry_t              ne;
  logic                wr;
  logic                u2;
  logic                isr;
  logic                cand;
  logic                fcand;
  logic                scan_done;
  logic [SW-1:0]       free_slot;
  logic [ID_WIDTH+15:0] id_ext;
  logic [ID_WIDTH+15:0] run_ext;
  logic [CW+6:0]       rc_ext;
  logic [CW+6:0]       wc_ext;
  logic [15:0]         run_age;

  assign e1 = entry_t'(ent_rdata);
  assign id_ext = {{ID_WIDTH{1'b0}}, in_task_id};
  assign run_ext = {16'd0, runner_id};
  assign rc_ext = {7'd0, ready_total};
  assign wc_ext = {7'd0, wait_total};
  assign run_age = tick_count - runner_stamp;
  assign scan_done = s2_valid && (s2_idx == SW'(SLOTS - 1));
  assign u2 = used[s2_idx];
  assign isr = runner_valid && (s2_idx == runner_slot);
  assign pre_we = s2_valid && (cmd.pass == PASS_PREFIX);

  parrs_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (idx),
    .rdata (ent_rdata)
  );

  parrs_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_prefix (
    .clk   (clk),
    .we    (pre_we),
    .waddr (s2_idx),
    .wdata (exp_count),
    .raddr (e1.rank),
    .rdata (below)
  );

  always_comb begin
    free_slot = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!used[j]) begin
        free_slot = SW'(j);
      end
    end
  end

  always_comb begin
    ne    = e2;
    wr    = 1'b0;
    cand  = 1'b0;
    fcand = 1'b0;
    case (cmd.pass)
      PASS_UPDATE: begin
        if (u2) begin
          wr = 1'b1;
          if (e2.q == Q_WAIT) begin
            if (expired[e2.rank]) begin
              ne.q    = Q_READY;
              ne.rank = SW'(ready_total) + SW'(below);
              ne.prio = PRIO_TOP;
            end else begin
              ne.rank = e2.rank - SW'(below);
            end
          end
          if (isr && preempt) begin
            if (io_q) begin
              ne.q     = Q_WAIT;
              ne.rank  = SW'(wait_total) - SW'(exp_count);
              ne.stamp = tick_count;
              ne.prio  = runner_prio;
            end else begin
              ne.q    = Q_READY;
              ne.rank = SW'(ready_total) + SW'(exp_count);
              ne.prio = (runner_prio < PRIO_MAX) ? runner_prio + 2'd1 : PRIO_MAX;
            end
          end
          if (ne.q == Q_READY) begin
            ne.age = ne.age + 4'd1;
            if (ne.age >= aging_threshold) begin
              ne.age = 4'd0;
              if (ne.prio != PRIO_TOP) begin
                ne.prio = ne.prio - 2'd1;
              end
            end
            cand = !runner_after && (!best_valid || (ne.prio < best_prio) ||
                   ((ne.prio == best_prio) && (ne.rank < best_rank)));
          end
        end
      end
      PASS_DISPATCH: begin
        if (u2 && (e2.q == Q_READY)) begin
          wr = 1'b1;
          if (s2_idx == best_slot) begin
            ne.q     = Q_NONE;
            ne.stamp = tick_count;
          end else if (e2.rank > best_rank) begin
            ne.rank = e2.rank - SW'(1);
          end
        end
      end
      PASS_FIND: begin
        fcand = u2 && (e2.id == id_q) && ((e2.q == Q_READY) || (e2.q == Q_WAIT)) &&
                (!found || (e2.q < found_q) ||
                 ((e2.q == found_q) && (e2.rank < found_rank)));
      end
      PASS_REMOVE: begin
        if (u2 && (e2.q == found_q) && (e2.rank > found_rank)) begin
          wr      = 1'b1;
          ne.rank = e2.rank - SW'(1);
        end
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = s2_idx;
    ent_wdata = ne;
    if (s2_valid && wr) begin
      ent_we = 1'b1;
    end else if (cmd.add_write) begin
      ent_we          = 1'b1;
      ent_waddr       = free_slot;
      ent_wdata.id    = id_q;
      ent_wdata.q     = Q_READY;
      ent_wdata.prio  = PRIO_ADD;
      ent_wdata.age   = 4'd0;
      ent_wdata.rank  = SW'(ready_total);
      ent_wdata.stamp = tick_count;
    end else if (cmd.setp_wr) begin
      ent_we         = 1'b1;
      ent_waddr      = found_slot;
      ent_wdata      = found_entry;
      ent_wdata.prio = np_q;
      if (found_q == Q_READY) begin
        ent_wdata.age = 4'd0;
      end
    end
  end

  always_comb begin
    sts.op          = op_q;
    sts.scan_done   = scan_done;
    sts.full        = &used;
    sts.runner_hit  = runner_valid && (runner_id == id_q);
    sts.prio_bad    = np_q > PRIO_MAX;
    sts.found       = found;
    sts.dispatch_ok = best_valid && !runner_valid;
    sts.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_ticks     <= SLICE_RESET;
      io_wait_ticks   <= IO_WAIT_RESET;
      aging_threshold <= AGING_RESET;
      used            <= '0;
      runner_valid    <= 1'b0;
      runner_slot     <= '0;
      tick_count      <= '0;
      ready_total     <= '0;
      wait_total      <= '0;
      issuing         <= 1'b0;
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      out_valid       <= 1'b0;
      op_q            <= OP_TICK;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          CFG_SLICE:   slice_ticks     <= cfg_data;
          CFG_IO_WAIT: io_wait_ticks   <= cfg_data;
          CFG_AGING:   aging_threshold <= cfg_data[3:0];
          default:     slice_ticks     <= slice_ticks;
        endcase
      end
      if (in_fire) begin
        op_q <= op_t'(in_op);
        id_q <= id_ext[ID_WIDTH-1:0];
        np_q <= in_new_priority;
        io_q <= in_io_request;
      end

      if (cmd.start) begin
        issuing <= 1'b1;
        idx     <= '0;
      end else if (issuing) begin
        idx <= idx + SW'(1);
        if (idx == SW'(SLOTS - 1)) begin
          issuing <= 1'b0;
        end
      end
      s1_valid <= issuing && !cmd.start;
      s1_idx   <= idx;
      s2_valid <= s1_valid;
      s2_idx   <= s1_idx;
      e2       <= e1;

      if (cmd.tick_begin) begin
        tick_count <= tick_count + 16'd1;
        expired    <= '0;
      end
      if (cmd.start) begin
        case (cmd.pass)
          PASS_PREFIX: exp_count <= '0;
          PASS_UPDATE: begin
            preempt      <= runner_valid && (run_age >= {1'b0, slice_ticks});
            runner_after <= runner_valid && !(run_age >= {1'b0, slice_ticks});
            best_valid   <= 1'b0;
          end
          PASS_FIND: found <= 1'b0;
          default: found <= found;
        endcase
      end

      if (s2_valid) begin
        case (cmd.pass)
          PASS_EXPIRE: begin
            if (u2 && (e2.q == Q_WAIT) &&
                ((tick_count - e2.stamp) >= {1'b0, io_wait_ticks})) begin
              expired[e2.rank] <= 1'b1;
            end
          end
          PASS_PREFIX: begin
            exp_count <= exp_count + CW'(expired[s2_idx]);
          end
          PASS_UPDATE: begin
            if (cand) begin
              best_valid <= 1'b1;
              best_slot  <= s2_idx;
              best_prio  <= ne.prio;
              best_rank  <= ne.rank;
              best_id    <= ne.id;
            end
            if (scan_done) begin
              ready_total  <= ready_total + exp_count + CW'(preempt && !io_q);
              wait_total   <= wait_total - exp_count + CW'(preempt && io_q);
              runner_valid <= runner_after;
            end
          end
          PASS_DISPATCH: begin
            if (scan_done) begin
              ready_total  <= ready_total - CW'(1);
              runner_valid <= 1'b1;
              runner_slot  <= best_slot;
              runner_id    <= best_id;
              runner_prio  <= best_prio;
              runner_stamp <= tick_count;
            end
          end
          PASS_FIND: begin
            if (fcand) begin
              found       <= 1'b1;
              found_slot  <= s2_idx;
              found_q     <= e2.q;
              found_rank  <= e2.rank;
              found_entry <= e2;
            end
          end
          PASS_REMOVE: begin
            if (scan_done) begin
              used[found_slot] <= 1'b0;
              if (found_q == Q_WAIT) begin
                wait_total <= wait_total - CW'(1);
              end else begin
                ready_total <= ready_total - CW'(1);
              end
            end
          end
          default: found <= found;
        endcase
      end

      if (cmd.add_write) begin
        used[free_slot] <= 1'b1;
        ready_total     <= ready_total + CW'(1);
      end
      if (cmd.finish_runner) begin
        runner_valid       <= 1'b0;
        used[runner_slot]  <= 1'b0;
      end
      if (cmd.setp_runner) begin
        runner_prio <= np_q;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= cmd.status;
      out_run_valid    <= runner_valid;
      out_run_id       <= runner_valid ? run_ext[15:0] : 16'd0;
      out_run_priority <= runner_valid ? runner_prio : PRIO_TOP;
      out_ready_count  <= rc_ext[6:0];
      out_wait_count   <= wc_ext[6:0];
    end
  end

endmodule

[rtl/priority_aging_round_robin_scheduler.sv]
// Top level of the priority scheduler with aging over a table of task slots.
//
// Channels: in_ch carries one operation per item (tick, add, finish, set
// priority); out_ch returns one result item per input item with the status,
// the running task and both queue occupancies after the operation. cfg writes
// slice_ticks (index 0), io_wait_ticks (1) and aging_threshold (2); it is
// always ready. The user must see that it is written only while the block
// is idle; the block itself does not enforce this. Add, and finish or set
// priority of the running task, do not sweep the slot table. Finish and set
// priority of a queued task sweep it once or twice. A tick sweeps it up to
// four times (expiry, prefix count, update with aging and selection,
// dispatch). Each sweep visits one slot per cycle through the entry
// memory's single read port.
// One item is worked at a time; a new item is taken once the previous result
// sits in the output register, which holds while the receiver stalls.
// Reset: empty table, no runner, tick count zero, registers at their defaults;
// the block is ready the cycle after reset is released.
module priority_aging_round_robin_scheduler import parrs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  parrs_in_if.sink   in_ch,
  parrs_out_if.source out_ch,
  parrs_cfg_if.sink  cfg
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic in_fire;

  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  parrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  parrs_dp #(.SLOTS(SLOTS), .ID_WIDTH(ID_WIDTH)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_fire),
    .in_op            (in_ch.op),
    .in_task_id       (in_ch.task_id),
    .in_new_priority  (in_ch.new_priority),
    .in_io_request    (in_ch.io_request),
    .cfg_fire         (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_run_valid    (out_ch.run_valid),
    .out_run_id       (out_ch.run_id),
    .out_run_priority (out_ch.run_priority),
    .out_ready_count  (out_ch.ready_count),
    .out_wait_count   (out_ch.wait_count)
  );

endmodule

[rtl/parrs_checker.sv]
// Port-level checks of the scheduler, bound to the top level.
module parrs_checker #(
  parameter int SLOTS = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        run_valid,
  input logic [15:0] run_id,
  input logic [1:0]  run_priority,
  input logic [6:0]  ready_count,
  input logic [6:0]  wait_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(run_id))
    else $error("result changed while stalled");

  a_idle_runner: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_valid |-> run_id == 16'd0 && run_priority == 2'd0)
    else $error("runner fields set without a runner");

  a_prio: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_valid |-> run_priority != 2'd3)
    else $error("runner priority out of range");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (9'(ready_count) + 9'(wait_count) + 9'(run_valid)) <= 9'(SLOTS))
    else $error("more tasks than slots");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule

bind priority_aging_round_robin_scheduler parrs_checker #(.SLOTS(SLOTS)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .run_valid    (out_ch.run_valid),
  .run_id       (out_ch.run_id),
  .run_priority (out_ch.run_priority),
  .ready_count  (out_ch.ready_count),
  .wait_count   (out_ch.wait_count)
);

[tb/tb_priority_aging_round_robin_scheduler.sv]
// Testbench of the aging priority scheduler: directed and randomized operations checked against a scheduler model.
`timescale 1ns / 100ps
module tb_priority_aging_round_robin_scheduler;
  import parrs_pkg::*;

  localparam int NSLOT = 64;

  typedef struct {
    logic [1:0]  status;
    logic        run_valid;
    logic [15:0] run_id;
    logic [1:0]  run_priority;
    logic [6:0]  ready_count;
    logic [6:0]  wait_count;
  } sched_result_t;

  class sched_board;
    logic [14:0] slice_ticks, io_wait_ticks;
    logic [3:0]  aging_threshold;
    bit          used[NSLOT];
    logic [15:0] id[NSLOT];
    logic [1:0]  qsel[NSLOT];
    logic [1:0]  prio[NSLOT];
    logic [3:0]  age[NSLOT];
    int          rank[NSLOT];
    logic [15:0] stamp[NSLOT];
    bit          running;
    int          run_slot;
    logic [15:0] now_ticks;
    int          ready_total, wait_total;
    sched_result_t pending[$];
    int          errors;

    function new();
      slice_ticks = SLICE_RESET;
      io_wait_ticks = IO_WAIT_RESET;
      aging_threshold = AGING_RESET;
      for (int s = 0; s < NSLOT; s++) used[s] = 0;
      running = 0;
      run_slot = 0;
      now_ticks = 0;
      ready_total = 0;
      wait_total = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [14:0] v);
      case (idx)
        CFG_SLICE: slice_ticks = v;
        CFG_IO_WAIT: io_wait_ticks = v;
        default: aging_threshold = v[3:0];
      endcase
    endfunction

    function bit queued(int s, logic [1:0] q);
      if (!used[s]) return 0;
      if (running && run_slot == s) return 0;
      return qsel[s] == q;
    endfunction

    function int at_rank(logic [1:0] q, int r);
      for (int s = 0; s < NSLOT; s++)
        if (queued(s, q) && rank[s] == r) return s;
      return -1;
    endfunction

    function void dequeue(int s);
      logic [1:0] q;
      q = qsel[s];
      for (int t = 0; t < NSLOT; t++)
        if (t != s && queued(t, q) && rank[t] > rank[s]) rank[t]--;
      if (q == Q_WAIT) begin
        if (wait_total > 0) wait_total--;
      end else begin
        if (ready_total > 0) ready_total--;
      end
      qsel[s] = Q_NONE;
    endfunction

    function void enqueue(int s, logic [1:0] q);
      qsel[s] = q;
      if (q == Q_WAIT) rank[s] = wait_total++;
      else rank[s] = ready_total++;
    endfunction

    function int lookup(logic [15:0] tid);
      int s, n;
      if (running && id[run_slot] == tid) return run_slot;
      for (int w = 0; w < 2; w++) begin
        n = w ? wait_total : ready_total;
        for (int r = 0; r < n; r++) begin
          s = at_rank(w ? Q_WAIT : Q_READY, r);
          if (s >= 0 && id[s] == tid) return s;
        end
      end
      return -1;
    endfunction

    function void advance(bit io);
      int r, s, best;
      logic [15:0] d;
      now_ticks++;
      r = 0;
      while (r < wait_total) begin
        s = at_rank(Q_WAIT, r);
        if (s < 0) break;
        d = now_ticks - stamp[s];
        if (d >= io_wait_ticks) begin
          dequeue(s);
          prio[s] = PRIO_TOP;
          enqueue(s, Q_READY);
        end else r++;
      end
      d = now_ticks - stamp[run_slot];
      if (running && d >= slice_ticks) begin
        s = run_slot;
        running = 0;
        if (io) begin
          stamp[s] = now_ticks;
          enqueue(s, Q_WAIT);
        end else begin
          if (prio[s] < PRIO_MAX) prio[s]++;
          enqueue(s, Q_READY);
        end
      end
      for (s = 0; s < NSLOT; s++) begin
        if (!queued(s, Q_READY)) continue;
        age[s] = age[s] + 4'd1;
        if (age[s] >= aging_threshold) begin
          age[s] = 0;
          if (prio[s] > 0) prio[s]--;
        end
      end
      if (!running) begin
        best = -1;
        for (r = 0; r < ready_total; r++) begin
          s = at_rank(Q_READY, r);
          if (s >= 0 && (best < 0 || prio[s] < prio[best])) best = s;
        end
        if (best >= 0) begin
          dequeue(best);
          stamp[best] = now_ticks;
          run_slot = best;
          running = 1;
        end
      end
    endfunction

    function void note_item(op_t op, logic [15:0] tid, logic [1:0] np, bit io);
      sched_result_t e;
      int s;
      e.status = ST_OK;
      case (op)
        OP_TICK: advance(io);
        OP_ADD: begin
          for (s = 0; s < NSLOT; s++) if (!used[s]) break;
          if (s >= NSLOT) e.status = ST_FULL;
          else begin
            used[s] = 1;
            id[s] = tid;
            prio[s] = PRIO_ADD;
            age[s] = 0;
            stamp[s] = now_ticks;
            enqueue(s, Q_READY);
          end
        end
        OP_FINISH: begin
          s = lookup(tid);
          if (s < 0) e.status = ST_NOT_FOUND;
          else if (running && run_slot == s) begin
            running = 0;
            used[s] = 0;
          end else begin
            dequeue(s);
            used[s] = 0;
          end
        end
        default: begin
          if (np > PRIO_MAX) e.status = ST_BAD_PRIO;
          else begin
            s = lookup(tid);
            if (s < 0) e.status = ST_NOT_FOUND;
            else begin
              prio[s] = np;
              if (!(running && run_slot == s) && qsel[s] == Q_READY) age[s] = 0;
            end
          end
        end
      endcase
      e.run_valid = running;
      e.run_id = running ? id[run_slot] : 16'd0;
      e.run_priority = running ? prio[run_slot] : 2'd0;
      e.ready_count = ready_total[6:0];
      e.wait_count = wait_total[6:0];
      pending.push_back(e);
    endfunction

    function void check_result(sched_result_t a);
      sched_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got status %0d run %0d/%0h", $time,
                 a.status, a.run_valid, a.run_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status || a.run_valid !== e.run_valid || a.run_id !== e.run_id ||
          a.run_priority !== e.run_priority || a.ready_count !== e.ready_count ||
          a.wait_count !== e.wait_count) begin
        $display("%0t: mismatch expected st=%0d rv=%0d id=%h pr=%0d rc=%0d wc=%0d", $time,
                 e.status, e.run_valid, e.run_id, e.run_priority, e.ready_count, e.wait_count);
        $display("%0t:          actual   st=%0d rv=%0d id=%h pr=%0d rc=%0d wc=%0d", $time,
                 a.status, a.run_valid, a.run_id, a.run_priority, a.ready_count, a.wait_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  parrs_in_if  in_ch();
  parrs_out_if out_ch();
  parrs_cfg_if cfg();

  priority_aging_round_robin_scheduler DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always #4 clk = ~clk;

  sched_board board = new();
  int hold_off = 0;
  bit long_stall = 0;
  logic [15:0] live_ids[$];

  initial begin
    in_ch.valid = 0;
    in_ch.op = OP_TICK;
    in_ch.task_id = 0;
    in_ch.new_priority = 0;
    in_ch.io_request = 0;
    cfg.valid = 0;
    cfg.index = CFG_SLICE;
    cfg.data = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    sched_result_t a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a.status = out_ch.status;
      a.run_valid = out_ch.run_valid;
      a.run_id = out_ch.run_id;
      a.run_priority = out_ch.run_priority;
      a.ready_count = out_ch.ready_count;
      a.wait_count = out_ch.wait_count;
      board.check_result(a);
    end
  end

  always @(negedge clk) begin
    if (rst) out_ch.ready <= 0;
    else if (long_stall) begin
      out_ch.ready <= 0;
      hold_off++;
    end else out_ch.ready <= ($urandom_range(0, 7) != 0) || (board.pending.size() > 40);
  end

  task automatic send_item(op_t op, logic [15:0] tid, logic [1:0] np, bit io);
    in_ch.valid = 1;
    in_ch.op = op;
    in_ch.task_id = tid;
    in_ch.new_priority = np;
    in_ch.io_request = io;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(op, tid, np, io);
    if (op == OP_ADD) live_ids.push_back(tid);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [14:0] v);
    cfg.valid = 1;
    cfg.index = idx;
    cfg.data = v;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, v);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int gap, burst, pick;
    logic [15:0] tid;
    op_t op;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        repeat (gap) @(negedge clk);
      end
      burst--;
      pick = $urandom_range(0, 99);
      op = pick < 45 ? OP_TICK : pick < 70 ? OP_ADD : pick < 85 ? OP_FINISH : OP_SETP;
      if (live_ids.size() != 0 && $urandom_range(0, 4) != 0)
        tid = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else tid = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
      send_item(op, tid, 2'($urandom_range(0, 3)), 1'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_FINISH, 16'h1234, 0, 0);
    send_item(OP_SETP, 16'h1234, 2'd3, 0);
    send_item(OP_SETP, 16'hFFFF, 2'd1, 0);
    send_item(OP_ADD, 16'hFFFF, 0, 0);
    send_item(OP_ADD, 16'h0000, 0, 0);
    send_item(OP_ADD, 16'h0000, 0, 0);
    send_item(OP_SETP, 16'h0000, 2'd2, 0);
    send_item(OP_TICK, 0, 0, 1);
    send_item(OP_SETP, 16'hFFFF, 2'd0, 0);
    send_item(OP_SETP, 16'hFFFF, 2'd3, 1);
    for (int i = 0; i < 12; i++) send_item(OP_TICK, 0, 0, 1);
    send_item(OP_FINISH, 16'hFFFF, 0, 0);
    send_item(OP_FINISH, 16'h0000, 0, 0);
    drain();
    write_cfg(CFG_SLICE, 15'd1);
    write_cfg(CFG_IO_WAIT, 15'd1);
    write_cfg(CFG_AGING, 15'd1);
    for (int i = 0; i < 70; i++) send_item(OP_ADD, 16'(i), 0, 0);
    random_phase(150);
    drain();
    write_cfg(CFG_SLICE, 15'd0);
    write_cfg(CFG_IO_WAIT, 15'd0);
    write_cfg(CFG_AGING, 15'd0);
    random_phase(120);
    drain();
    write_cfg(CFG_SLICE, 15'h7FFF);
    write_cfg(CFG_IO_WAIT, 15'h7FFF);
    write_cfg(CFG_AGING, 15'd15);
    fork
      begin
        long_stall = 1;
        while (hold_off < 300) @(negedge clk);
        long_stall = 0;
      end
      random_phase(120);
    join
    drain();
    write_cfg(CFG_SLICE, 15'd3);
    write_cfg(CFG_IO_WAIT, 15'd5);
    write_cfg(CFG_AGING, 15'd2);
    for (int i = 0; i < 64; i++) send_item(OP_FINISH, live_ids[i % live_ids.size()], 0, 0);
    live_ids.delete();
    random_phase(350);
    drain();
    repeat (300) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("priority_aging_round_robin_scheduler regression: pass");
    else
      $display("priority_aging_round_robin_scheduler regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("priority_aging_round_robin_scheduler regression: fail");
    $finish;
  end
endmodule

[priority_aging_round_robin_scheduler.f]
rtl/parrs_pkg.sv
rtl/parrs_if.sv
rtl/parrs_ram.sv
rtl/parrs_ctrl.sv
rtl/parrs_dp.sv
rtl/priority_aging_round_robin_scheduler.sv
rtl/parrs_checker.sv
tb/tb_priority_aging_round_robin_scheduler.sv
